// ===== rtl/core/pwrp_pkg.sv =====
// shared types and codes for the priority weighted random picker
// no dependencies; imported by every module of the block
`default_nettype none

package pwrp_pkg;

    localparam int FIELD_W = 16;
    localparam int RND_W   = 31;
    localparam int LEFT_W  = 5;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_SELECT = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_NOP    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [FIELD_W-1:0] priority_req;
        logic [FIELD_W-1:0] weight;
        logic [FIELD_W-1:0] port;
        logic [FIELD_W-1:0] target_tag;
        logic [RND_W-1:0]   random_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [FIELD_W-1:0] chosen_priority;
        logic [FIELD_W-1:0] chosen_weight;
        logic [FIELD_W-1:0] chosen_port;
        logic [FIELD_W-1:0] chosen_tag;
        logic [LEFT_W-1:0]  entries_left;
    } out_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] prio;
        logic [FIELD_W-1:0] wgt;
        logic [FIELD_W-1:0] prt;
        logic [FIELD_W-1:0] tag;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_MIN_RD,
        S_MIN_EV,
        S_SUM_RD,
        S_SUM_EV,
        S_DIV,
        S_PICK_RD,
        S_PICK_EV,
        S_SHF_RD,
        S_SHF_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic latch;
        logic ins;
        logic clr;
        logic sel_fail;
        logic rd_cur;
        logic rd_nxt;
        logic min_ev;
        logic sum_ev;
        logic pick_ev;
        logic idx_clr;
        logic idx_inc;
        logic div_start;
        logic r_load;
        logic shf_wr;
        logic dec;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  empty;
        logic  last;
        logic  more;
        logic  found;
        logic  div_done;
        logic  out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/pwrp_div.sv =====
// restoring divider, one quotient bit per cycle, remainder only
// depends on pwrp_pkg
`default_nettype none

module pwrp_div #(
    parameter int DVW = 21
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [pwrp_pkg::RND_W-1:0] dividend,
    input  wire logic [DVW-1:0]         divisor,
    output logic                        done,
    output logic [DVW-1:0]              rem
);
    import pwrp_pkg::*;

    localparam int CNTW = $clog2(RND_W + 1);

    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [RND_W-1:0] dvd_reg, dvd_next;
    logic [DVW-1:0]   rem_reg, rem_next;
    logic [DVW-1:0]   d_reg;
    logic [DVW:0]     trial;

    assign trial = {rem_reg, dvd_reg[RND_W-1]};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[RND_W-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
                rem_next = DVW'(trial - {1'b0, d_reg});
            else
                rem_next = trial[DVW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(RND_W - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (start)
            d_reg <= divisor;
    end

    assign done = !busy_reg && !start;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pwrp_ctrl.sv =====
// sequencing state machine for insert, select, clear and no-op
// depends on pwrp_pkg
`default_nettype none

module pwrp_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire pwrp_pkg::sts_t sts,
    output pwrp_pkg::cmd_t      cmd
);
    import pwrp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_EXEC;
            S_EXEC:
            begin
                if (sts.func == FUNC_SELECT && !sts.empty)
                    state_next = S_MIN_RD;
                else
                    state_next = S_DONE;
            end
            S_MIN_RD:  state_next = S_MIN_EV;
            S_MIN_EV:  state_next = sts.last ? S_SUM_RD : S_MIN_RD;
            S_SUM_RD:  state_next = S_SUM_EV;
            S_SUM_EV:  state_next = sts.last ? S_DIV : S_SUM_RD;
            S_DIV:     if (sts.div_done) state_next = S_PICK_RD;
            S_PICK_RD: state_next = S_PICK_EV;
            S_PICK_EV:
            begin
                if (sts.found)
                    state_next = S_SHF_RD;
                else if (sts.last)
                    state_next = S_DONE;
                else
                    state_next = S_PICK_RD;
            end
            S_SHF_RD:  state_next = sts.more ? S_SHF_WR : S_DONE;
            S_SHF_WR:  state_next = S_SHF_RD;
            S_DONE:    if (sts.out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            S_EXEC:
            begin
                cmd.ins      = (sts.func == FUNC_INSERT);
                cmd.clr      = (sts.func == FUNC_CLEAR);
                cmd.sel_fail = (sts.func == FUNC_SELECT) && sts.empty;
                cmd.idx_clr  = 1'b1;
            end
            S_MIN_RD, S_SUM_RD, S_PICK_RD: cmd.rd_cur = 1'b1;
            S_MIN_EV:
            begin
                cmd.min_ev  = 1'b1;
                cmd.idx_clr = sts.last;
                cmd.idx_inc = !sts.last;
            end
            S_SUM_EV:
            begin
                cmd.sum_ev    = 1'b1;
                cmd.div_start = sts.last;
                cmd.idx_inc   = !sts.last;
            end
            S_DIV:
            begin
                cmd.r_load  = sts.div_done;
                cmd.idx_clr = sts.div_done;
            end
            S_PICK_EV:
            begin
                cmd.pick_ev  = 1'b1;
                cmd.sel_fail = !sts.found && sts.last;
                cmd.idx_inc  = !sts.found && !sts.last;
            end
            S_SHF_RD:
            begin
                cmd.rd_nxt = sts.more;
                cmd.dec    = !sts.more;
            end
            S_SHF_WR:
            begin
                cmd.shf_wr  = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            S_DONE:    cmd.load_out = sts.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/pwrp_dp.sv =====
// entry table memory, scan registers, weight sums and output register
// depends on pwrp_pkg and pwrp_div
`default_nettype none

module pwrp_dp #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire pwrp_pkg::in_item_t  in_item,
    input  wire pwrp_pkg::cmd_t      cmd,
    output pwrp_pkg::sts_t           sts,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output pwrp_pkg::out_item_t      out_item
);
    import pwrp_pkg::*;

    localparam int IW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int SW  = $clog2(MAX_ENTRIES * 65535 + 1);
    localparam int DVW = SW + 1;

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    in_item_t      req_reg;
    logic [CW-1:0] count_reg;
    logic [IW-1:0] idx_reg;
    logic [FIELD_W-1:0] min_reg;
    logic [SW-1:0] wsum_reg, csum_reg;
    logic [FIELD_W-1:0] r_reg;
    status_t       res_status_reg;
    entry_t        res_entry_reg;
    out_item_t     out_reg;
    logic          out_valid_reg;

    logic [CW-1:0] idx_p1;
    logic [IW-1:0] rd_addr;
    logic          match;
    logic [SW-1:0] csum_next;
    logic [SW-1:0] wsum_next;
    logic          div_done;
    logic [DVW-1:0] div_rem;
    logic [31:0]   cnt_ext;
    entry_t        new_entry;

    assign idx_p1    = CW'(idx_reg) + 1'b1;
    assign rd_addr   = cmd.rd_nxt ? IW'(idx_p1) : idx_reg;
    assign match     = (rd_data_reg.prio == min_reg);
    assign csum_next = csum_reg + SW'(rd_data_reg.wgt);
    // group sum including the entry under evaluation, so the divisor
    // taken on the last sum step already holds the last weight
    assign wsum_next = (cmd.sum_ev && match) ? wsum_reg + SW'(rd_data_reg.wgt) : wsum_reg;
    assign cnt_ext   = 32'(count_reg);
    assign new_entry = '{prio: req_reg.priority_req, wgt: req_reg.weight,
                         prt: req_reg.port, tag: req_reg.target_tag};

    pwrp_div #(.DVW(DVW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (req_reg.random_value),
        .divisor  (DVW'(wsum_next) + 1'b1),
        .done     (div_done),
        .rem      (div_rem)
    );

    // table memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.ins && count_reg != CW'(MAX_ENTRIES))
            mem[count_reg[IW-1:0]] <= new_entry;
        else if (cmd.shf_wr)
            mem[idx_reg] <= rd_data_reg;
        if (cmd.rd_cur || cmd.rd_nxt)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ins && count_reg != CW'(MAX_ENTRIES))
                count_reg <= count_reg + 1'b1;
            else if (cmd.clr)
                count_reg <= '0;
            else if (cmd.dec)
                count_reg <= count_reg - 1'b1;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg        <= in_item;
            res_status_reg <= ST_OK;
            res_entry_reg  <= '0;
        end
        if (cmd.ins && count_reg == CW'(MAX_ENTRIES))
            res_status_reg <= ST_FULL;
        if (cmd.sel_fail)
            res_status_reg <= ST_EMPTY;
        if (cmd.idx_clr)
        begin
            idx_reg  <= '0;
            csum_reg <= '0;
        end
        else if (cmd.idx_inc)
            idx_reg <= IW'(idx_p1);
        if (cmd.min_ev && (idx_reg == '0 || rd_data_reg.prio < min_reg))
            min_reg <= rd_data_reg.prio;
        if (cmd.min_ev && cmd.idx_clr)
            wsum_reg <= '0;
        else if (cmd.sum_ev && match)
            wsum_reg <= wsum_next;
        if (cmd.r_load)
            r_reg <= div_rem[FIELD_W-1:0];
        if (cmd.pick_ev && match)
            csum_reg <= csum_next;
        if (cmd.pick_ev && sts.found)
            res_entry_reg <= rd_data_reg;
        if (cmd.load_out)
        begin
            out_reg.status          <= res_status_reg;
            out_reg.chosen_priority <= res_entry_reg.prio;
            out_reg.chosen_weight   <= res_entry_reg.wgt;
            out_reg.chosen_port     <= res_entry_reg.prt;
            out_reg.chosen_tag      <= res_entry_reg.tag;
            out_reg.entries_left    <= cnt_ext[LEFT_W-1:0];
        end
    end

    always_comb
    begin
        sts.func     = func_t'(req_reg.func);
        sts.empty    = (count_reg == '0);
        sts.last     = (idx_p1 == count_reg);
        sts.more     = (idx_p1 < count_reg);
        sts.found    = match && (csum_next >= SW'(r_reg));
        sts.div_done = div_done;
        sts.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above table depth");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ins && count_reg == CW'(MAX_ENTRIES)) |=> $stable(count_reg))
        else $error("insert into full table changed count");

    a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shf_wr |-> (idx_p1 < count_reg))
        else $error("shift past last stored entry");

endmodule

`default_nettype wire

// ===== rtl/core/priority_weighted_random_picker.sv =====
// top level of the priority weighted random picker
// depends on pwrp_pkg, pwrp_ctrl, pwrp_dp and pwrp_div
`default_nettype none

// Weighted server picker by priority group. The table keeps up to
// MAX_ENTRIES entries in insertion order in a memory with one write port
// and a registered read. Each input item gives exactly one result item.
// Insert, clear and the unused code go from accept through the execute
// state to the done state, which loads the output register. Select walks
// the table twice with a read and an evaluate state per entry (minimum
// priority, group weight sum), runs the 31-step restoring remainder unit
// for the draw, then walks again up to the pick and shifts the tail down
// with a read and a write state per moved entry; the done state then
// loads the result and holds there while the output stalls.
// One item is worked on at a time; a finished result waits in the output
// register and the block takes the next item while it waits.

module priority_weighted_random_picker #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire pwrp_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output pwrp_pkg::out_item_t      out_item
);
    import pwrp_pkg::*;

    // command and status between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    pwrp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table, sums, remainder unit and output register
    pwrp_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire
